// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Gregorian date counter package
// Operation codes, default date and calendar arithmetic helpers.
// ----------------------------------------------------------------------------
package gdc_pkg;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2,
        OP_DIFF = 2'd3
    } op_t;

    localparam logic [3:0]  DEF_MONTH = 4'd1;
    localparam logic [4:0]  DEF_DAY   = 5'd1;
    localparam logic [13:0] DEF_YEAR  = 14'd1930;
    localparam logic [21:0] DIFF_MAX  = 22'h3FFFFF;

    localparam int DAYNUM_W = 23;

    // Division by 100 through the reciprocal 5243 / 2^19, exact below 16384.
    function automatic logic [26:0] recip100(input logic [13:0] v);
        return 27'(v) * 27'd5243;
    endfunction

    function automatic logic [7:0] div100(input logic [13:0] v);
        logic [26:0] p;
        p = recip100(v);
        return p[26:19];
    endfunction

    // A multiple of 100 leaves a fraction below 2048 in the product, any other
    // value leaves one above 5000.
    function automatic logic leap_year(input logic [13:0] y);
        logic [26:0] p;
        logic        by100;
        p     = recip100(y);
        by100 = (p[18:11] == 8'd0);
        return ((y[1:0] == 2'd0) && !by100) || (by100 && (p[20:19] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month, with the year starting in March.
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] off;
        case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    function automatic logic [DAYNUM_W-1:0] day_number(input logic [3:0] m,
                                                       input logic [4:0] d,
                                                       input logic [13:0] y);
        logic [13:0]         yy;
        logic [11:0]         q4;
        logic [7:0]          q100;
        logic [7:0]          q400;
        logic [DAYNUM_W-1:0] sum;
        yy   = (m <= 4'd2) ? y - 14'd1 : y;
        q4   = yy[13:2];
        q100 = div100(yy);
        q400 = div100({2'b00, q4});
        sum  = DAYNUM_W'(yy) * DAYNUM_W'(365) + DAYNUM_W'(q4) - DAYNUM_W'(q100)
             + DAYNUM_W'(q400) + DAYNUM_W'(month_offset(m)) + DAYNUM_W'(d)
             - DAYNUM_W'(1);
        return sum;
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_counter_top.sv =====
// ----------------------------------------------------------------------------
// Gregorian date counter
// Holds one calendar date; sets it, steps it by a day either way and measures
// the distance in days to an operand date.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid / in_ready     op, date_month, date_day, date_year
//  out      out_valid / out_ready   out_month, out_day, out_year,
//                                   day_difference, operand_invalid
//
//  An item is taken into an input register, and when the result register can
//  advance, one pass of logic updates the stored date and loads the result
//  register: one item per cycle sustained while out_ready holds. The day
//  difference path (two day numbers and a subtract) sets the clock period.
//  Reset loads 1/1/1930 and empties both registers. A stalled result holds
//  while the input register still takes one further item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gregorian_date_counter_top #(
    parameter int MIN_YEAR = 1000,
    parameter int MAX_YEAR = 9999
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  date_month,
    input  logic [4:0]  date_day,
    input  logic [13:0] date_year,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [13:0] out_year,
    output logic [21:0] day_difference,
    output logic        operand_invalid
);

    localparam logic [13:0] MinYear = 14'(MIN_YEAR);
    localparam logic [13:0] MaxYear = 14'(MAX_YEAR);

    logic                in_valid_reg;
    gdc_pkg::op_t        op_reg;
    logic [3:0]          m_reg;
    logic [4:0]          d_reg;
    logic [13:0]         y_reg;

    logic [3:0]          cur_month_reg, cur_month_next;
    logic [4:0]          cur_day_reg, cur_day_next;
    logic [13:0]         cur_year_reg, cur_year_next;

    logic                out_valid_reg;
    logic [3:0]          out_month_reg;
    logic [4:0]          out_day_reg;
    logic [13:0]         out_year_reg;
    logic [21:0]         diff_reg, diff_next;
    logic                bad_reg, bad_next;

    logic                advance;
    logic                opnd_ok;
    logic [4:0]          cur_len;
    logic [4:0]          prev_len;
    logic [3:0]          diff_m;
    logic [4:0]          diff_d;
    logic [13:0]         diff_y;
    logic [gdc_pkg::DAYNUM_W-1:0] num_a, num_b, num_delta;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= gdc_pkg::op_t'(op);
            m_reg  <= date_month;
            d_reg  <= date_day;
            y_reg  <= date_year;
        end
    end

    assign opnd_ok = (y_reg >= MinYear) && (y_reg <= MaxYear)
                  && (m_reg >= 4'd1) && (m_reg <= 4'd12) && (d_reg >= 5'd1)
                  && (d_reg <= gdc_pkg::month_len(m_reg, gdc_pkg::leap_year(y_reg)));

    assign cur_len  = gdc_pkg::month_len(cur_month_reg, gdc_pkg::leap_year(cur_year_reg));
    assign prev_len = gdc_pkg::month_len(cur_month_reg - 4'd1,
                                         gdc_pkg::leap_year(cur_year_reg));

    assign diff_m = opnd_ok ? m_reg : gdc_pkg::DEF_MONTH;
    assign diff_d = opnd_ok ? d_reg : gdc_pkg::DEF_DAY;
    assign diff_y = opnd_ok ? y_reg : gdc_pkg::DEF_YEAR;

    assign num_a     = gdc_pkg::day_number(cur_month_reg, cur_day_reg, cur_year_reg);
    assign num_b     = gdc_pkg::day_number(diff_m, diff_d, diff_y);
    assign num_delta = (num_a > num_b) ? num_a - num_b : num_b - num_a;

    always_comb
    begin
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        cur_year_next  = cur_year_reg;
        diff_next      = 22'd0;
        bad_next       = 1'b0;
        case (op_reg)
            gdc_pkg::OP_SET:
            begin
                if (opnd_ok)
                begin
                    cur_month_next = m_reg;
                    cur_day_next   = d_reg;
                    cur_year_next  = y_reg;
                end
                else
                begin
                    cur_month_next = gdc_pkg::DEF_MONTH;
                    cur_day_next   = gdc_pkg::DEF_DAY;
                    cur_year_next  = gdc_pkg::DEF_YEAR;
                    bad_next       = 1'b1;
                end
            end
            gdc_pkg::OP_NEXT:
            begin
                if (!((cur_year_reg >= MaxYear) && (cur_month_reg == 4'd12)
                      && (cur_day_reg == 5'd31)))
                begin
                    if (cur_day_reg < cur_len)
                    begin
                        cur_day_next = cur_day_reg + 5'd1;
                    end
                    else
                    begin
                        cur_day_next = 5'd1;
                        if (cur_month_reg >= 4'd12)
                        begin
                            cur_month_next = 4'd1;
                            cur_year_next  = cur_year_reg + 14'd1;
                        end
                        else
                        begin
                            cur_month_next = cur_month_reg + 4'd1;
                        end
                    end
                end
            end
            gdc_pkg::OP_PREV:
            begin
                if (!((cur_year_reg <= MinYear) && (cur_month_reg == 4'd1)
                      && (cur_day_reg == 5'd1)))
                begin
                    if (cur_day_reg > 5'd1)
                    begin
                        cur_day_next = cur_day_reg - 5'd1;
                    end
                    else if (cur_month_reg <= 4'd1)
                    begin
                        cur_month_next = 4'd12;
                        cur_year_next  = cur_year_reg - 14'd1;
                        cur_day_next   = 5'd31;
                    end
                    else
                    begin
                        cur_month_next = cur_month_reg - 4'd1;
                        cur_day_next   = prev_len;
                    end
                end
            end
            gdc_pkg::OP_DIFF:
            begin
                bad_next  = !opnd_ok;
                diff_next = num_delta[gdc_pkg::DAYNUM_W-1] ? gdc_pkg::DIFF_MAX
                          : num_delta[21:0];
            end
            default:
            begin
                bad_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_month_reg <= gdc_pkg::DEF_MONTH;
            cur_day_reg   <= gdc_pkg::DEF_DAY;
            cur_year_reg  <= gdc_pkg::DEF_YEAR;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                cur_month_reg <= cur_month_next;
                cur_day_reg   <= cur_day_next;
                cur_year_reg  <= cur_year_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_month_reg <= cur_month_next;
            out_day_reg   <= cur_day_next;
            out_year_reg  <= cur_year_next;
            diff_reg      <= diff_next;
            bad_reg       <= bad_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_month       = out_month_reg;
    assign out_day         = out_day_reg;
    assign out_year        = out_year_reg;
    assign day_difference  = diff_reg;
    assign operand_invalid = bad_reg;

    `ASSERT_NEXT(a_item_held, in_valid_reg && !advance, in_valid_reg)
    `ASSERT_NEXT(a_result_made, in_valid_reg && advance, out_valid_reg)
    `ASSERT_NEXT(a_no_repeat, out_valid_reg && out_ready && !in_valid_reg, !out_valid_reg)
    `ASSERT_SAME(a_month_sane, 1'b1, (cur_month_reg >= 4'd1) && (cur_month_reg <= 4'd12))
    `ASSERT_SAME(a_day_sane, 1'b1, cur_day_reg != 5'd0)

endmodule

// ===== tb/sv/tb_gregorian_date_counter_top.sv =====
// ----------------------------------------------------------------------------
// Gregorian date counter testbench
// Drives set, next day, previous day and day difference items into the block
// and checks every result against an in-bench calendar predictor. Directed
// items cover the field extremes, the leap rule and the year bounds. Random
// runs of well-formed date sequences and noise follow, with bursty input,
// patterned output stalls and one long output hold that fills the block.
// ----------------------------------------------------------------------------
module tb_gregorian_date_counter_top;

    localparam int MIN_YEAR = 1000;
    localparam int MAX_YEAR = 9999;
    localparam int DIFF_SAT = 4194303;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] year;
        logic [21:0] diff;
        logic        invalid;
    } date_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [3:0]  date_month;
    logic [4:0]  date_day;
    logic [13:0] date_year;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [13:0] out_year;
    logic [21:0] day_difference;
    logic        operand_invalid;

    logic [3:0]  model_month;
    logic [4:0]  model_day;
    logic [13:0] model_year;

    date_result_t expected_dates[$];
    int           mismatch_count = 0;
    int           burst_left = 0;
    bit           gaps_on = 1'b1;
    int           hold_request = 0;

    gregorian_date_counter_top #(
        .MIN_YEAR(MIN_YEAR),
        .MAX_YEAR(MAX_YEAR)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .date_month(date_month),
        .date_day(date_day),
        .date_year(date_year),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_month(out_month),
        .out_day(out_day),
        .out_year(out_year),
        .day_difference(day_difference),
        .operand_invalid(operand_invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == 2)
        begin
            return is_leap_year(y) ? 29 : 28;
        end
        if (m <= 7)
        begin
            return (m % 2 == 0) ? 30 : 31;
        end
        return (m % 2 == 0) ? 31 : 30;
    endfunction

    function automatic bit date_is_valid(input int unsigned m, input int unsigned d,
                                         input int unsigned y);
        if (y < MIN_YEAR || y > MAX_YEAR)
        begin
            return 1'b0;
        end
        if (m < 1 || m > 12)
        begin
            return 1'b0;
        end
        return d >= 1 && d <= days_in_month(m, y);
    endfunction

    function automatic int unsigned serial_day(input int unsigned m, input int unsigned d,
                                               input int unsigned y);
        int unsigned yy;
        int unsigned mm;
        int unsigned doy;
        yy  = (m <= 2) ? y - 1 : y;
        mm  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mm + 2) / 5 + d - 1;
        return yy * 365 + yy / 4 - yy / 100 + yy / 400 + doy;
    endfunction

    function automatic date_result_t predict_date_step(input gdc_pkg::op_t o,
                                                       input logic [3:0] m,
                                                       input logic [4:0] d,
                                                       input logic [13:0] y);
        date_result_t res;
        int unsigned  a;
        int unsigned  b;
        int unsigned  gap_days;
        logic [3:0]   om;
        logic [4:0]   od;
        logic [13:0]  oy;
        res.diff    = '0;
        res.invalid = 1'b0;
        case (o)
            gdc_pkg::OP_SET:
            begin
                if (date_is_valid(m, d, y))
                begin
                    model_month = m;
                    model_day   = d;
                    model_year  = y;
                end
                else
                begin
                    model_month = 4'd1;
                    model_day   = 5'd1;
                    model_year  = 14'd1930;
                    res.invalid = 1'b1;
                end
            end
            gdc_pkg::OP_NEXT:
            begin
                if (!(model_year >= MAX_YEAR && model_month == 4'd12 && model_day == 5'd31))
                begin
                    if (model_day < days_in_month(model_month, model_year))
                    begin
                        model_day = model_day + 5'd1;
                    end
                    else
                    begin
                        model_day = 5'd1;
                        if (model_month >= 4'd12)
                        begin
                            model_month = 4'd1;
                            model_year  = model_year + 14'd1;
                        end
                        else
                        begin
                            model_month = model_month + 4'd1;
                        end
                    end
                end
            end
            gdc_pkg::OP_PREV:
            begin
                if (!(model_year <= MIN_YEAR && model_month == 4'd1 && model_day == 5'd1))
                begin
                    if (model_day > 5'd1)
                    begin
                        model_day = model_day - 5'd1;
                    end
                    else
                    begin
                        if (model_month <= 4'd1)
                        begin
                            model_month = 4'd12;
                            model_year  = model_year - 14'd1;
                        end
                        else
                        begin
                            model_month = model_month - 4'd1;
                        end
                        model_day = 5'(days_in_month(model_month, model_year));
                    end
                end
            end
            default:
            begin
                om = m;
                od = d;
                oy = y;
                if (!date_is_valid(m, d, y))
                begin
                    om          = 4'd1;
                    od          = 5'd1;
                    oy          = 14'd1930;
                    res.invalid = 1'b1;
                end
                a        = serial_day(model_month, model_day, model_year);
                b        = serial_day(om, od, oy);
                gap_days = (a > b) ? a - b : b - a;
                if (gap_days > DIFF_SAT)
                begin
                    gap_days = DIFF_SAT;
                end
                res.diff = 22'(gap_days);
            end
        endcase
        res.month = model_month;
        res.day   = model_day;
        res.year  = model_year;
        return res;
    endfunction

    task automatic send_item(input gdc_pkg::op_t o, input logic [3:0] m, input logic [4:0] d,
                             input logic [13:0] y);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 20);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   = 1'b1;
        op         = o;
        date_month = m;
        date_day   = d;
        date_year  = y;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_dates.push_back(predict_date_step(o, m, d, y));
        if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    task automatic pick_valid_date(output logic [3:0] m, output logic [4:0] d,
                                   output logic [13:0] y);
        int unsigned yr;
        int unsigned mo;
        int unsigned len;
        case ($urandom_range(0, 9))
            0:       yr = $urandom_range(MIN_YEAR, MIN_YEAR + 3);
            1:       yr = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
            2:       yr = $urandom_range(10, 99) * 100;
            3:       yr = $urandom_range(3, 24) * 400;
            default: yr = $urandom_range(MIN_YEAR, MAX_YEAR);
        endcase
        mo  = $urandom_range(1, 12);
        len = days_in_month(mo, yr);
        case ($urandom_range(0, 3))
            0:       d = 5'd1;
            1:       d = 5'(len);
            default: d = 5'($urandom_range(1, len));
        endcase
        m = 4'(mo);
        y = 14'(yr);
    endtask

    task automatic test_set_checks();
        send_item(gdc_pkg::OP_SET, 4'd1, 5'd1, 14'd1000);
        send_item(gdc_pkg::OP_SET, 4'd12, 5'd31, 14'd9999);
        send_item(gdc_pkg::OP_SET, 4'd0, 5'd1, 14'd2000);
        send_item(gdc_pkg::OP_SET, 4'd13, 5'd1, 14'd2000);
        send_item(gdc_pkg::OP_SET, 4'd15, 5'd31, 14'd16383);
        send_item(gdc_pkg::OP_SET, 4'd4, 5'd31, 14'd2001);
        send_item(gdc_pkg::OP_SET, 4'd4, 5'd0, 14'd2001);
        send_item(gdc_pkg::OP_SET, 4'd2, 5'd29, 14'd1900);
        send_item(gdc_pkg::OP_SET, 4'd2, 5'd29, 14'd2000);
        send_item(gdc_pkg::OP_SET, 4'd2, 5'd29, 14'd2023);
        send_item(gdc_pkg::OP_SET, 4'd1, 5'd1, 14'd999);
        send_item(gdc_pkg::OP_SET, 4'd1, 5'd1, 14'd10000);
        send_item(gdc_pkg::OP_SET, 4'd1, 5'd1, 14'd0);
    endtask

    task automatic test_calendar_bounds();
        send_item(gdc_pkg::OP_SET, 4'd12, 5'd31, 14'd9999);
        send_item(gdc_pkg::OP_NEXT, 4'd0, 5'd0, 14'd0);
        send_item(gdc_pkg::OP_PREV, 4'd0, 5'd0, 14'd0);
        send_item(gdc_pkg::OP_SET, 4'd1, 5'd1, 14'd1000);
        send_item(gdc_pkg::OP_PREV, 4'd0, 5'd0, 14'd0);
        send_item(gdc_pkg::OP_NEXT, 4'd0, 5'd0, 14'd0);
        send_item(gdc_pkg::OP_SET, 4'd3, 5'd1, 14'd2000);
        send_item(gdc_pkg::OP_PREV, 4'd0, 5'd0, 14'd0);
        send_item(gdc_pkg::OP_SET, 4'd3, 5'd1, 14'd1900);
        send_item(gdc_pkg::OP_PREV, 4'd0, 5'd0, 14'd0);
        send_item(gdc_pkg::OP_SET, 4'd12, 5'd31, 14'd1999);
        send_item(gdc_pkg::OP_NEXT, 4'd0, 5'd0, 14'd0);
    endtask

    task automatic test_day_difference();
        send_item(gdc_pkg::OP_SET, 4'd1, 5'd1, 14'd1000);
        send_item(gdc_pkg::OP_DIFF, 4'd12, 5'd31, 14'd9999);
        send_item(gdc_pkg::OP_DIFF, 4'd0, 5'd0, 14'd0);
        send_item(gdc_pkg::OP_DIFF, 4'd1, 5'd1, 14'd1000);
    endtask

    task automatic test_random_calendar(input int count);
        int          sent;
        int          run;
        int          pick;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [13:0] y;
        sent = 0;
        while (sent < count)
        begin
            gaps_on = ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 9) < 7)
            begin
                pick_valid_date(m, d, y);
                send_item(gdc_pkg::OP_SET, m, d, y);
                sent++;
                run = $urandom_range(1, 12);
                repeat (run)
                begin
                    pick = $urandom_range(0, 4);
                    if (pick == 0)
                    begin
                        pick_valid_date(m, d, y);
                        send_item(gdc_pkg::OP_DIFF, m, d, y);
                    end
                    else if (pick <= 2)
                    begin
                        send_item(gdc_pkg::OP_NEXT, 4'($urandom_range(0, 15)),
                                  5'($urandom_range(0, 31)), 14'($urandom_range(0, 16383)));
                    end
                    else
                    begin
                        send_item(gdc_pkg::OP_PREV, 4'($urandom_range(0, 15)),
                                  5'($urandom_range(0, 31)), 14'($urandom_range(0, 16383)));
                    end
                    sent++;
                end
            end
            else
            begin
                send_item(gdc_pkg::op_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          5'($urandom_range(0, 31)), 14'($urandom_range(0, 16383)));
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_hold();
        logic [3:0]  m;
        logic [4:0]  d;
        logic [13:0] y;
        gaps_on = 1'b0;
        hold_request = 300;
        pick_valid_date(m, d, y);
        send_item(gdc_pkg::OP_SET, m, d, y);
        repeat (40)
        begin
            pick_valid_date(m, d, y);
            send_item(gdc_pkg::op_t'($urandom_range(1, 3)), m, d, y);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin : receiver
        int hold_left;
        int mode;
        int window;
        int phase;
        hold_left = 0;
        mode      = 0;
        window    = 0;
        phase     = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                if (window == 0)
                begin
                    mode   = $urandom_range(0, 3);
                    window = $urandom_range(20, 80);
                end
                window--;
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = 1'($urandom_range(0, 1));
                    2:       out_ready = (phase % 3 != 0);
                    default: out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        date_result_t exp_date;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                report_mismatch("result with no item waiting");
            end
            else
            begin
                exp_date = expected_dates.pop_front();
                if (out_month !== exp_date.month)
                begin
                    report_mismatch($sformatf("out_month %0d, want %0d",
                                              out_month, exp_date.month));
                end
                if (out_day !== exp_date.day)
                begin
                    report_mismatch($sformatf("out_day %0d, want %0d", out_day, exp_date.day));
                end
                if (out_year !== exp_date.year)
                begin
                    report_mismatch($sformatf("out_year %0d, want %0d",
                                              out_year, exp_date.year));
                end
                if (day_difference !== exp_date.diff)
                begin
                    report_mismatch($sformatf("day_difference %0d, want %0d",
                                              day_difference, exp_date.diff));
                end
                if (operand_invalid !== exp_date.invalid)
                begin
                    report_mismatch($sformatf("operand_invalid %0b, want %0b",
                                              operand_invalid, exp_date.invalid));
                end
            end
        end
    end

    initial
    begin : main_sequence
        int drain;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = gdc_pkg::OP_SET;
        date_month  = '0;
        date_day    = '0;
        date_year   = '0;
        model_month = 4'd1;
        model_day   = 5'd1;
        model_year  = 14'd1930;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_set_checks();
        test_calendar_bounds();
        test_day_difference();
        test_random_calendar(500);
        test_output_hold();
        test_random_calendar(450);

        @(negedge clk);
        in_valid = 1'b0;
        drain = 0;
        while (expected_dates.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (expected_dates.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
